>>> rtl/pidc_pkg.sv
// Shared types, constants and helper functions of the clamped PID controller.
package pidc_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned LIM_W    = 31;
	localparam int unsigned WIDE_W   = 33;
	localparam int unsigned ACC_W    = 51;
	localparam int unsigned TERM_W   = 48;
	localparam int unsigned NUM_W    = 49;
	localparam int unsigned CNT_W    = 6;
	localparam int unsigned IDX_W    = 3;

	localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(WIDE_W);
	localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(NUM_W);

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_GAIN_P          = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I          = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D          = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_FF         = 3'd3;
	localparam logic [IDX_W-1:0] REG_EFFORT_LIMIT    = 3'd4;
	localparam logic [IDX_W-1:0] REG_INTEGRATE_BELOW = 3'd5;
	localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [DATA_W-1:0] GAIN_P_RST = 32'h0001_0000;
	localparam logic [LIM_W-1:0]  LIMIT_RST  = 31'h000A_0000;
	localparam logic [LIM_W-1:0]  BELOW_RST  = 31'h7FFF_FFFF;

	localparam logic ACTION_CLEAR = 1'b1;

	// Index of the product term that is being accumulated.
	typedef enum logic [1:0] {
		TERM_P  = 2'd0,
		TERM_I  = 2'd1,
		TERM_D  = 2'd2,
		TERM_FF = 2'd3
	} term_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RATE,
		ST_DIV,
		ST_INTEG,
		ST_IMUL,
		ST_TERM,
		ST_TMUL,
		ST_CLAMP
	} state_t;

	// Magnitude of a 33-bit two's complement value.
	function automatic logic [WIDE_W-1:0] mag33(input logic [WIDE_W-1:0] v);
		return v[WIDE_W-1] ? (WIDE_W'(0) - v) : v;
	endfunction

	// Clamp a wide signed value to the range [-lim, +lim].
	function automatic logic [DATA_W-1:0] clamp_wide(input logic signed [ACC_W-1:0] v,
			input logic [LIM_W-1:0] lim);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		logic signed [ACC_W-1:0] res;
		hi = $signed({(ACC_W-LIM_W)'(0), lim});
		lo = -hi;
		if (v > hi) begin
			res = hi;
		end else if (v < lo) begin
			res = lo;
		end else begin
			res = v;
		end
		return res[DATA_W-1:0];
	endfunction

endpackage

>>> rtl/pidc_mul.sv
// Bit-serial shift-add multiplier of two magnitudes, one multiplier bit per cycle.
module pidc_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [pidc_pkg::DATA_W-1:0]       mcand,
	input  logic [pidc_pkg::WIDE_W-1:0]       mplier,
	output logic                              done,
	output logic [pidc_pkg::TERM_W-1:0]       prod
);
	import pidc_pkg::*;

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [DATA_W-1:0]          mcand_q;
	logic [DATA_W+WIDE_W-1:0]   prod_q;
	logic [WIDE_W-1:0]          partial;

	// The upper half gathers the partial sum while the multiplier shifts out below.
	assign partial = {1'b0, prod_q[DATA_W+WIDE_W-1:WIDE_W]}
		+ (prod_q[0] ? {1'b0, mcand_q} : WIDE_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			prod_q  <= {DATA_W'(0), mplier};
		end else if (busy_q) begin
			prod_q <= {partial, prod_q[WIDE_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = prod_q[TERM_W+15:16];

endmodule

>>> rtl/pidc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module pidc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pidc_pkg::NUM_W-1:0]     dividend,
	input  logic [pidc_pkg::LIM_W-1:0]     divisor,
	output logic                           done,
	output logic [pidc_pkg::NUM_W-1:0]     quotient
);
	import pidc_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [LIM_W-1:0]      divisor_q;
	logic [LIM_W-1:0]      rem_q;
	logic [NUM_W-1:0]      quo_q;
	logic [LIM_W:0]        shifted;
	logic [LIM_W+1:0]      trial;
	logic                  fits;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor_q};
	assign fits    = !trial[LIM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out of the top of quo_q as quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			quo_q     <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial[LIM_W-1:0] : shifted[LIM_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/pid_controller_clamped_unit.sv
// Top level of the clamped PID controller with setpoint feedforward and anti-windup.
// Usage: configuration writes go over cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and registers should be written only while the block is idle.
// Input transactions (in_valid, in_stall) carry action, interval, setpoint,
// measurement, setpoint_rate, measurement_rate and rate_given. A clear action zeroes
// the integral and the previous measurement in the accepting cycle and gives no result.
// An update gives one drive value on the output channel (out_valid, out_stall).
// Steps of an update: the measurement rate is taken as given, or as zero when the
// measurement is unchanged, else derived in the bit-serial divider (49 quotient bits).
// The integration goes through the multiplier only when the error is below the
// threshold. The four gain products then go through the bit-serial multiplier in
// turn (33 steps each). The next input can be accepted in the same cycle in which
// out_valid rises.
// in_stall stays high from acceptance until the result is in the output register, so
// one update is in flight at a time; a waiting result does not block the next input.
// If the receiver stalls while a second result is ready, the block holds it and keeps
// in_stall high until the output register frees up.
// Reset loads the register defaults, zeroes the state and empties the output register.
module pid_controller_clamped_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pidc_pkg::IDX_W-1:0]        cfg_index,
	input  logic [pidc_pkg::DATA_W-1:0]       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [pidc_pkg::LIM_W-1:0]        interval,
	input  logic signed [pidc_pkg::DATA_W-1:0] setpoint,
	input  logic signed [pidc_pkg::DATA_W-1:0] measurement,
	input  logic signed [pidc_pkg::DATA_W-1:0] setpoint_rate,
	input  logic signed [pidc_pkg::DATA_W-1:0] measurement_rate,
	input  logic                              rate_given,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pidc_pkg::DATA_W-1:0] drive
);
	import pidc_pkg::*;

	state_t state_q, state_d;

	logic signed [DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q, gain_ff_q;
	logic [LIM_W-1:0]         effort_limit_q, integrate_below_q, integral_limit_q;
	logic signed [DATA_W-1:0] last_meas_q, integ_q;

	logic [LIM_W-1:0]         interval_q;
	logic [DATA_W-1:0]        setpoint_q, sp_rate_q, meas_rate_q;
	logic                     rate_given_q;
	logic [WIDE_W-1:0]        err_q, diff_q, deriv_q;
	logic [ACC_W-1:0]         acc_q;
	term_t                    term_q;
	logic                     neg_q;

	logic                     out_valid_q;
	logic [DATA_W-1:0]        drive_q;

	logic                     in_take, out_take, out_free;
	logic                     mul_start, mul_done, div_start, div_done;
	logic [DATA_W-1:0]        mul_a;
	logic [WIDE_W-1:0]        mul_b;
	logic [TERM_W-1:0]        mul_prod;
	logic [NUM_W-1:0]         div_quo;
	logic [WIDE_W-1:0]        op_a, op_b, mag_a, mag_b, err_mag, diff_mag;
	logic [ACC_W-1:0]         term_val;
	logic [DATA_W-1:0]        rate_div, rate_now;
	logic                     rate_sat;
	logic [WIDE_W-1:0]        deriv_now;
	logic [ACC_W-1:0]         integ_sum;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign err_mag  = mag33(err_q);
	assign diff_mag = mag33(diff_q);

	// Saturate the derived rate in the sign of the measurement difference.
	assign rate_sat = (div_quo[NUM_W-1:DATA_W-1] != '0);
	always_comb begin
		if (!diff_q[WIDE_W-1]) begin
			rate_div = rate_sat ? 32'h7FFF_FFFF : {1'b0, div_quo[DATA_W-2:0]};
		end else begin
			rate_div = rate_sat ? 32'h8000_0000 : (DATA_W'(0) - {1'b0, div_quo[DATA_W-2:0]});
		end
	end

	always_comb begin
		if (state_q == ST_DIV) begin
			rate_now = rate_div;
		end else if (rate_given_q) begin
			rate_now = meas_rate_q;
		end else begin
			rate_now = '0;
		end
	end

	assign deriv_now = {sp_rate_q[DATA_W-1], sp_rate_q} - {rate_now[DATA_W-1], rate_now};

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			ST_INTEG: begin
				op_a = {2'b00, interval_q};
				op_b = err_q;
			end
			ST_TERM: begin
				case (term_q)
					TERM_P: begin
						op_a = {gain_p_q[DATA_W-1], gain_p_q};
						op_b = err_q;
					end
					TERM_I: begin
						op_a = {gain_i_q[DATA_W-1], gain_i_q};
						op_b = {integ_q[DATA_W-1], integ_q};
					end
					TERM_D: begin
						op_a = {gain_d_q[DATA_W-1], gain_d_q};
						op_b = deriv_q;
					end
					TERM_FF: begin
						op_a = {gain_ff_q[DATA_W-1], gain_ff_q};
						op_b = {setpoint_q[DATA_W-1], setpoint_q};
					end
					default: begin
						op_a = '0;
						op_b = '0;
					end
				endcase
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mag_a = mag33(op_a);
	assign mag_b = mag33(op_b);
	assign mul_a = mag_a[DATA_W-1:0];
	assign mul_b = mag_b;

	// The product is truncated toward zero before the sign is applied.
	assign term_val  = neg_q ? (ACC_W'(0) - {3'b000, mul_prod}) : {3'b000, mul_prod};
	assign integ_sum = {{(ACC_W-DATA_W){integ_q[DATA_W-1]}}, integ_q} + term_val;

	pidc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_a),
		.mplier (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pidc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({diff_mag, 16'h0000}),
		.divisor  (interval_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_take && action != ACTION_CLEAR) begin
					state_d = ST_RATE;
				end
			end
			ST_RATE: begin
				if (!rate_given_q && diff_q != '0) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_INTEG;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_INTEG;
				end
			end
			ST_INTEG: begin
				if (err_mag < {2'b00, integrate_below_q}) begin
					mul_start = 1'b1;
					state_d   = ST_IMUL;
				end else begin
					state_d = ST_TERM;
				end
			end
			ST_IMUL: begin
				if (mul_done) begin
					state_d = ST_TERM;
				end
			end
			ST_TERM: begin
				mul_start = 1'b1;
				state_d   = ST_TMUL;
			end
			ST_TMUL: begin
				if (mul_done) begin
					state_d = (term_q == TERM_FF) ? ST_CLAMP : ST_TERM;
				end
			end
			ST_CLAMP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration registers and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q          <= GAIN_P_RST;
			gain_i_q          <= '0;
			gain_d_q          <= '0;
			gain_ff_q         <= '0;
			effort_limit_q    <= LIMIT_RST;
			integrate_below_q <= BELOW_RST;
			integral_limit_q  <= LIMIT_RST;
			last_meas_q       <= '0;
			integ_q           <= '0;
			term_q            <= TERM_P;
			out_valid_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GAIN_P:          gain_p_q          <= cfg_data;
					REG_GAIN_I:          gain_i_q          <= cfg_data;
					REG_GAIN_D:          gain_d_q          <= cfg_data;
					REG_GAIN_FF:         gain_ff_q         <= cfg_data;
					REG_EFFORT_LIMIT:    effort_limit_q    <= cfg_data[LIM_W-1:0];
					REG_INTEGRATE_BELOW: integrate_below_q <= cfg_data[LIM_W-1:0];
					REG_INTEGRAL_LIMIT:  integral_limit_q  <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (in_take) begin
				if (action == ACTION_CLEAR) begin
					last_meas_q <= '0;
					integ_q     <= '0;
				end else begin
					last_meas_q <= measurement;
				end
			end
			if (state_q == ST_INTEG) begin
				term_q <= TERM_P;
			end
			if (state_q == ST_IMUL && mul_done) begin
				integ_q <= clamp_wide(integ_sum, integral_limit_q);
			end
			if (state_q == ST_TMUL && mul_done) begin
				term_q <= term_t'(term_q + 2'd1);
			end
			if (state_q == ST_CLAMP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-transaction operands and the accumulator.
	always_ff @(posedge clk) begin
		if (in_take) begin
			interval_q   <= interval;
			setpoint_q   <= setpoint;
			sp_rate_q    <= setpoint_rate;
			meas_rate_q  <= measurement_rate;
			rate_given_q <= rate_given;
			err_q        <= {setpoint[DATA_W-1], setpoint}
				- {measurement[DATA_W-1], measurement};
			diff_q       <= {measurement[DATA_W-1], measurement}
				- {last_meas_q[DATA_W-1], last_meas_q};
		end
		if ((state_q == ST_RATE && (rate_given_q || diff_q == '0))
				|| (state_q == ST_DIV && div_done)) begin
			deriv_q <= deriv_now;
		end
		if (mul_start) begin
			neg_q <= op_a[WIDE_W-1] ^ op_b[WIDE_W-1];
		end
		if (state_q == ST_INTEG) begin
			acc_q <= '0;
		end else if (state_q == ST_TMUL && mul_done) begin
			acc_q <= acc_q + term_val;
		end
		if (state_q == ST_CLAMP && out_free) begin
			drive_q <= clamp_wide(acc_q, effort_limit_q);
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule
